// ===== rtl/fpp_pkg.sv =====
// shared widths, register indexes and types of the fisheye point projection
package fpp_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int CFG_W   = 24;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = MAG_W + CFG_W;
  localparam int NUM_W   = PROD_W + FRAC_W;
  localparam int DEN_W   = PROD_W - FRAC_W + 1;
  localparam int Q_W     = COORD_W;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] CFG_MODE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_DIST  = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_SCALE = IDX_W'(2);

  localparam logic MODE_CIRC = 1'b0;
  localparam logic MODE_RHOZ = 1'b1;

  localparam logic [CFG_W-1:0] SCALE_RST = CFG_W'(65536);
  localparam logic [DEN_W-1:0] ONE_Q24   = DEN_W'(1) << 24;

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
    logic             nx;
    logic             ny;
    logic             nz;
  } pt_t;

endpackage

// ===== rtl/fpp_if.sv =====
// valid/ready channels for input points and projected results
interface fpp_in_if import fpp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface fpp_out_if import fpp_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] proj_x;
  logic signed [COORD_W-1:0] proj_y;
  logic                      saturated;
  modport source (output valid, proj_x, proj_y, saturated, input ready);
  modport sink (input valid, proj_x, proj_y, saturated, output ready);
endinterface

// ===== rtl/fisheye_point_projection_top.sv =====
// fisheye point projection: top level with registers, multipliers and output stage
//
// Takes one Q16.16 point per cycle while the output does not stall and returns
// its fisheye (mode 0) or rho-z (mode 1) projection. The depth is set by the
// square root (one root bit per stage) and the two-lane divider (one quotient
// bit per stage), plus abs, square, select/multiply, denominator and saturation
// stages. The whole pipeline advances together: when a result waits at the
// output, the input is held off in that cycle and resumes as soon as the result
// is taken. Configuration writes take effect at once and are meant to be done
// while no point is in flight.
module fisheye_point_projection_top import fpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  fpp_in_if.sink           pt_in_i,
  fpp_out_if.source        pt_out_o
);

  localparam logic [Q_W-1:0] LIM_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] LIM_NEG = {1'b1, {(Q_W-1){1'b0}}};

  logic             mode_q;
  logic [CFG_W-1:0] dist_q;
  logic [CFG_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CIRC;
      dist_q  <= '0;
      scale_q <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  mode_q  <= cfg_wdata_i[0];
        CFG_DIST:  dist_q  <= cfg_wdata_i;
        CFG_SCALE: scale_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || pt_out_o.ready;
  assign pt_in_i.ready = en;

  // stage 0: magnitudes and signs
  logic v0_q;
  pt_t  p0_q;
  pt_t  p0_d;

  always_comb begin
    p0_d.nx = pt_in_i.pos_x[COORD_W-1];
    p0_d.ny = pt_in_i.pos_y[COORD_W-1];
    p0_d.nz = pt_in_i.pos_z[COORD_W-1];
    p0_d.ax = p0_d.nx ? MAG_W'(-pt_in_i.pos_x) : MAG_W'(pt_in_i.pos_x);
    p0_d.ay = p0_d.ny ? MAG_W'(-pt_in_i.pos_y) : MAG_W'(pt_in_i.pos_y);
    p0_d.az = p0_d.nz ? MAG_W'(-pt_in_i.pos_z) : MAG_W'(pt_in_i.pos_z);
  end

  // stage 1: squares
  logic            v1_q;
  pt_t             p1_q;
  logic [SQ_W-1:0] sqx_q;
  logic [SQ_W-1:0] sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= pt_in_i.valid;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q  <= p0_d;
      p1_q  <= p0_q;
      sqx_q <= SQ_W'(p0_q.ax) * SQ_W'(p0_q.ax);
      sqy_q <= SQ_W'(p0_q.ay) * SQ_W'(p0_q.ay);
    end
  end

  logic              rt_valid;
  logic [ROOT_W-1:0] root;
  pt_t               rt_side;

  fpp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .rad_i   (sqx_q + sqy_q),
    .side_i  (p1_q),
    .valid_o (rt_valid),
    .root_o  (root),
    .side_o  (rt_side)
  );

  // stage 3: operand select and products
  logic [MAG_W-1:0]  n_sel [2];
  logic [MAG_W-1:0]  m_sel [2];
  logic              g_sel [2];
  logic              v3_q;
  logic [PROD_W-1:0] prodn_q [2];
  logic [PROD_W-1:0] prodm_q [2];
  logic              neg3_q  [2];

  always_comb begin
    case (mode_q)
      MODE_RHOZ: begin
        n_sel[0] = rt_side.az;
        m_sel[0] = rt_side.az;
        g_sel[0] = rt_side.nz;
        n_sel[1] = root;
        m_sel[1] = root;
        g_sel[1] = rt_side.ny || (rt_side.ay == '0);
      end
      default: begin
        n_sel[0] = rt_side.ax;
        m_sel[0] = root;
        g_sel[0] = rt_side.nx;
        n_sel[1] = rt_side.ay;
        m_sel[1] = root;
        g_sel[1] = rt_side.ny;
      end
    endcase
  end

  // stage 4: numerator and denominator
  logic             v4_q;
  logic [NUM_W-1:0] num_q  [2];
  logic [DEN_W-1:0] den_q  [2];
  logic             neg4_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v3_q <= rt_valid;
      v4_q <= v3_q;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en) begin
        prodn_q[l] <= PROD_W'(n_sel[l]) * PROD_W'(scale_q);
        prodm_q[l] <= PROD_W'(m_sel[l]) * PROD_W'(dist_q);
        neg3_q[l]  <= g_sel[l];
        num_q[l]   <= {prodn_q[l], FRAC_W'(0)};
        den_q[l]   <= ONE_Q24 + DEN_W'(prodm_q[l][PROD_W-1:FRAC_W]);
        neg4_q[l]  <= neg3_q[l];
      end
    end
  end

  logic           dv_valid;
  logic [Q_W-1:0] quo  [2];
  logic           ovf  [2];
  logic           qneg [2];

  fpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .neg_i   (neg4_q),
    .valid_o (dv_valid),
    .q_o     (quo),
    .ovf_o   (ovf),
    .neg_o   (qneg)
  );

  // output stage: clip, sign, register
  logic [Q_W-1:0] lim  [2];
  logic           clip [2];
  logic [Q_W-1:0] mag  [2];
  logic [Q_W-1:0] res  [2];

  for (genvar l = 0; l < 2; l++) begin : g_sat
    always_comb begin
      lim[l]  = qneg[l] ? LIM_NEG : LIM_POS;
      clip[l] = ovf[l] || (quo[l] > lim[l]);
      mag[l]  = clip[l] ? lim[l] : quo[l];
      res[l]  = qneg[l] ? (~mag[l] + Q_W'(1)) : mag[l];
    end
  end

  logic [COORD_W-1:0] px_q;
  logic [COORD_W-1:0] py_q;
  logic               sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= res[0];
      py_q  <= res[1];
      sat_q <= clip[0] || clip[1];
    end
  end

  assign pt_out_o.valid     = out_valid_q;
  assign pt_out_o.proj_x    = px_q;
  assign pt_out_o.proj_y    = py_q;
  assign pt_out_o.saturated = sat_q;

endmodule

// ===== rtl/fpp_sqrt.sv =====
// pipelined integer square root, one root bit per stage, with point sideband
module fpp_sqrt import fpp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   rad_i,
  input  pt_t               side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output pt_t               side_o
);

  localparam int NSTEP = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              v_q    [NSTEP+1];
  logic [SQ_W-1:0]   rad_q  [NSTEP+1];
  logic [ROOT_W-1:0] root_q [NSTEP+1];
  logic [REM_W-1:0]  rem_q  [NSTEP+1];
  pt_t               side_q [NSTEP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      root_q[0] <= '0;
      rem_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= NSTEP; s++) begin : g_step
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      t     = {rem_q[s-1][REM_W-3:0], rad_q[s-1][SQ_W-1 -: 2]};
      trial = REM_W'({root_q[s-1], 2'b01});
      ge    = (t >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (t - trial) : t;
        root_q[s] <= {root_q[s-1][ROOT_W-2:0], ge};
        rad_q[s]  <= rad_q[s-1] << 2;
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[NSTEP];
  assign root_o  = root_q[NSTEP];
  assign side_o  = side_q[NSTEP];

endmodule

// ===== rtl/fpp_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
module fpp_div import fpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i [2],
  input  logic [DEN_W-1:0] den_i [2],
  input  logic             neg_i [2],
  output logic             valid_o,
  output logic [Q_W-1:0]   q_o   [2],
  output logic             ovf_o [2],
  output logic             neg_o [2]
);

  localparam int NSTEP = Q_W;

  logic v_q [NSTEP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar s = 1; s <= NSTEP; s++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  assign valid_o = v_q[NSTEP];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DEN_W-1:0] rem_q [NSTEP+1];
    logic [DEN_W-1:0] den_q [NSTEP+1];
    logic [Q_W-1:0]   lo_q  [NSTEP+1];
    logic [Q_W-1:0]   qt_q  [NSTEP+1];
    logic             ovf_q [NSTEP+1];
    logic             neg_q [NSTEP+1];
    logic [DEN_W-1:0] hi;

    // quotient needs more than Q_W bits exactly when the top part reaches den
    assign hi = DEN_W'(num_i[l][NUM_W-1:Q_W]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= hi;
        den_q[0] <= den_i[l];
        lo_q[0]  <= num_i[l][Q_W-1:0];
        qt_q[0]  <= '0;
        ovf_q[0] <= (hi >= den_i[l]);
        neg_q[0] <= neg_i[l];
      end
    end

    for (genvar s = 1; s <= NSTEP; s++) begin : g_step
      logic [DEN_W:0] t;
      logic [DEN_W:0] d;
      logic           ge;

      always_comb begin
        t  = {rem_q[s-1], lo_q[s-1][Q_W-1]};
        d  = {1'b0, den_q[s-1]};
        ge = (t >= d);
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? DEN_W'(t - d) : DEN_W'(t);
          den_q[s] <= den_q[s-1];
          lo_q[s]  <= lo_q[s-1] << 1;
          qt_q[s]  <= {qt_q[s-1][Q_W-2:0], ge};
          ovf_q[s] <= ovf_q[s-1];
          neg_q[s] <= neg_q[s-1];
        end
      end
    end

    assign q_o[l]   = qt_q[NSTEP];
    assign ovf_o[l] = ovf_q[NSTEP];
    assign neg_o[l] = neg_q[NSTEP];
  end

endmodule

// ===== rtl/fpp_checker.sv =====
// port-level checks of the fisheye point projection, bound to the top level
module fpp_checker import fpp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COORD_W-1:0] proj_x_i,
  input logic [COORD_W-1:0] proj_y_i,
  input logic               saturated_i
);

  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(proj_x_i) && $stable(proj_y_i)
      && $stable(saturated_i))
    else $error("result changed while stalled");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input held off with empty output");

  a_flow_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input held off while output drains");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> proj_x_i == C_MAX || proj_x_i == C_MIN
      || proj_y_i == C_MAX || proj_y_i == C_MIN)
    else $error("saturated flag without a clipped value");

endmodule

bind fisheye_point_projection_top fpp_checker u_fpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pt_in_i.ready),
  .out_valid_i (pt_out_o.valid),
  .out_ready_i (pt_out_o.ready),
  .proj_x_i    (pt_out_o.proj_x),
  .proj_y_i    (pt_out_o.proj_y),
  .saturated_i (pt_out_o.saturated)
);
